// ===== hdl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, types and command/status bundles of the symmetric FIR
// decimator.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// sizing
	localparam int MAX_TAPS   = 64;
	localparam int MAX_DECIM  = 16;
	localparam int COEF_DEPTH = MAX_TAPS / 2 + 1;

	localparam int DADDR_W = $clog2(MAX_TAPS);
	localparam int CADDR_W = $clog2(COEF_DEPTH);
	localparam int LEN_W   = $clog2(MAX_TAPS + 1);
	localparam int PH_W    = $clog2(MAX_DECIM + 1);
	localparam int STEP_W  = $clog2(COEF_DEPTH + 1);

	// field widths
	localparam int OP_W       = 1;
	localparam int CIDX_W     = 6;
	localparam int COEF_W     = 18;
	localparam int SAMPLE_W   = 24;
	localparam int TAPCNT_W   = 7;
	localparam int DECIM_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// arithmetic
	localparam int SUM_W       = SAMPLE_W + 1;
	localparam int PROD_W      = SUM_W + COEF_W;
	localparam int ACC_W       = PROD_W + $clog2(COEF_DEPTH) + 1;
	localparam int FRAC_W      = COEF_W - 1;
	localparam int RND_W       = ACC_W - FRAC_W;
	localparam int DRAIN_CYC   = 3;
	localparam int DRAIN_W     = $clog2(DRAIN_CYC + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DECIM_RATE = CFG_IDX_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_COEF   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              coef_wr;
		logic              samp_wr;
		logic              issue;
		logic [STEP_W-1:0] step;
		logic [LEN_W-1:0]  len;
		logic              acc_clr;
		logic              round;
		logic              load_out;
	} sfd_cmd_t;

	typedef struct packed {
		logic out_free;
	} sfd_stat_t;

endpackage

// ===== hdl/sfd_ifs.sv =====
// ----------------------------------------------------------------------------
// sfd_ifs
// Valid/ready channels of the decimator: input items and filtered results.
// ----------------------------------------------------------------------------
interface sfd_in_if;
	import sfd_pkg::*;

	logic                        valid;
	logic                        ready;
	op_t                         op;
	logic [CIDX_W-1:0]           coef_index;
	logic signed [COEF_W-1:0]    coef_value;
	logic signed [SAMPLE_W-1:0]  sample;

	modport source (output valid, op, coef_index, coef_value, sample, input ready);
	modport sink   (input valid, op, coef_index, coef_value, sample, output ready);
endinterface

interface sfd_out_if;
	import sfd_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_W-1:0]  filtered;

	modport source (output valid, filtered, input ready);
	modport sink   (input valid, filtered, output ready);
endinterface

// ===== hdl/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// Controller: config registers, fill/phase bookkeeping and the sequencer that
// walks the tap pairs through the datapath.
// ----------------------------------------------------------------------------
module sfd_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           feed_valid,
	input  sfd_pkg::op_t                   feed_op,
	output logic                           feed_ready,
	output sfd_pkg::sfd_cmd_t              cmd,
	input  sfd_pkg::sfd_stat_t             stat
);
	import sfd_pkg::*;

	state_t             state_q, state_d;
	logic [TAPCNT_W-1:0] tap_q;
	logic [DECIM_W-1:0]  decim_q;
	logic [LEN_W-1:0]   fill_q, fill_d;
	logic [PH_W-1:0]    phase_q, phase_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [DRAIN_W-1:0] drain_q, drain_d;
	logic [LEN_W-1:0]   eff_len;
	logic [PH_W-1:0]    eff_rate;
	logic [STEP_W-1:0]  last_step;
	logic               accept;
	logic               emit;

	// out-of-range settings are clamped
	always_comb begin
		if (tap_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(tap_q) > MAX_TAPS) begin
			eff_len = LEN_W'(MAX_TAPS);
		end else begin
			eff_len = LEN_W'(tap_q);
		end
		if (decim_q == '0) begin
			eff_rate = PH_W'(1);
		end else if (32'(decim_q) > MAX_DECIM) begin
			eff_rate = PH_W'(MAX_DECIM);
		end else begin
			eff_rate = PH_W'(decim_q);
		end
	end

	// pairs plus the center tap when the length is odd
	assign last_step = STEP_W'(len_q >> 1) + STEP_W'(len_q[0]) - STEP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q   <= TAPCNT_W'(1);
			decim_q <= DECIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_COUNT:  tap_q   <= cfg_data[TAPCNT_W-1:0];
				REG_DECIM_RATE: decim_q <= cfg_data[DECIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			phase_q <= '0;
			len_q   <= LEN_W'(1);
			step_q  <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			phase_q <= phase_d;
			len_q   <= len_d;
			step_q  <= step_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		phase_d    = phase_q;
		len_d      = len_q;
		step_d     = step_q;
		drain_d    = drain_q;
		emit       = 1'b0;
		feed_ready = 1'b0;
		accept     = 1'b0;
		cmd        = '0;
		cmd.step   = step_q;
		cmd.len    = len_q;

		case (state_q)
			ST_IDLE: begin
				feed_ready = 1'b1;
				accept     = feed_valid;
				if (accept && feed_op == OP_COEF) begin
					cmd.coef_wr = 1'b1;
				end else if (accept) begin
					cmd.samp_wr = 1'b1;
					if (fill_q < eff_len) begin
						fill_d = fill_q + LEN_W'(1);
						emit   = (fill_q + LEN_W'(1) == eff_len);
					end else if (phase_q == '0) begin
						emit = 1'b1;
					end else begin
						phase_d = phase_q - PH_W'(1);
					end
					if (emit) begin
						phase_d     = eff_rate - PH_W'(1);
						len_d       = eff_len;
						step_d      = '0;
						cmd.acc_clr = 1'b1;
						state_d     = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (step_q == last_step) begin
					drain_d = '0;
					state_d = ST_DRAIN;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_W'(DRAIN_CYC - 1)) begin
					state_d = ST_ROUND;
				end else begin
					drain_d = drain_q + DRAIN_W'(1);
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== hdl/sfd_dpath.sv =====
// ----------------------------------------------------------------------------
// sfd_dpath
// Datapath: circular sample buffer, coefficient table, pre-add / multiply /
// accumulate pipeline, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module sfd_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfd_pkg::sfd_cmd_t      cmd,
	output sfd_pkg::sfd_stat_t     stat,
	sfd_in_if.sink                 feed,
	sfd_out_if.source              result
);
	import sfd_pkg::*;

	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(8388607);
	localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(8388608);
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

	// physical address of the sample that is k places behind the newest one
	function automatic logic [DADDR_W-1:0] tap_addr(
		input logic [DADDR_W-1:0] wp,
		input logic [LEN_W-1:0]   k
	);
		logic signed [LEN_W+1:0] d;
		d = $signed({{(LEN_W + 2 - DADDR_W){1'b0}}, wp}) - (LEN_W + 2)'(1)
			- $signed({2'b00, k});
		if (d < 0) begin
			d = d + (LEN_W + 2)'(MAX_TAPS);
		end
		return d[DADDR_W-1:0];
	endfunction

	logic [DADDR_W-1:0]       wp_q;
	logic [LEN_W-1:0]         cnt_q;
	logic [COEF_DEPTH-1:0]    cvalid_q;
	logic [LEN_W-1:0]         ka, kb;
	logic [DADDR_W-1:0]       ra_a, ra_b;
	logic [CADDR_W-1:0]       ra_c, wa_c;
	logic                     center;
	logic                     coef_hit;
	logic [SAMPLE_W-1:0]      da, db;
	logic [COEF_W-1:0]        dc;
	logic                     v_s1, va_s1, vb_s1, vc_s1;
	logic                     v_s2, v_s3;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [COEF_W-1:0] coef_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc_q, acc_rnd;
	logic signed [RND_W-1:0]  rnd_q;
	logic signed [SUM_W-1:0]  xa, xb;
	logic signed [SAMPLE_W-1:0] sat_val;
	logic                     out_valid_q;
	logic [SAMPLE_W-1:0]      filtered_q;

	assign ka     = LEN_W'(cmd.step);
	assign kb     = cmd.len - LEN_W'(1) - LEN_W'(cmd.step);
	assign center = cmd.len[0] && (LEN_W'(cmd.step) == (cmd.len >> 1));
	assign ra_a   = tap_addr(wp_q, ka);
	assign ra_b   = tap_addr(wp_q, kb);
	assign ra_c   = CADDR_W'(cmd.step);
	assign wa_c   = CADDR_W'(feed.coef_index);
	assign coef_hit = 32'(feed.coef_index) < COEF_DEPTH;

	// two copies of the sample buffer give two reads per cycle
	sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_samp_a (
		.clk   (clk),
		.we    (cmd.samp_wr),
		.waddr (wp_q),
		.wdata (feed.sample),
		.raddr (ra_a),
		.rdata (da)
	);

	sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_samp_b (
		.clk   (clk),
		.we    (cmd.samp_wr),
		.waddr (wp_q),
		.wdata (feed.sample),
		.raddr (ra_b),
		.rdata (db)
	);

	sfd_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef (
		.clk   (clk),
		.we    (cmd.coef_wr && coef_hit),
		.waddr (wa_c),
		.wdata (feed.coef_value),
		.raddr (ra_c),
		.rdata (dc)
	);

	// write pointer, sample count (entries never written read as zero),
	// coefficient valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			cvalid_q <= '0;
		end else begin
			if (cmd.samp_wr) begin
				wp_q <= (32'(wp_q) == MAX_TAPS - 1) ? '0 : wp_q + DADDR_W'(1);
				if (32'(cnt_q) != MAX_TAPS) begin
					cnt_q <= cnt_q + LEN_W'(1);
				end
			end
			if (cmd.coef_wr && coef_hit) begin
				cvalid_q[wa_c] <= 1'b1;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1: read flags travel with the RAM reads
	always_ff @(posedge clk) begin
		va_s1 <= ka < cnt_q;
		vb_s1 <= (kb < cnt_q) && !center;
		vc_s1 <= cvalid_q[ra_c];
	end

	assign xa = va_s1 ? SUM_W'($signed(da)) : '0;
	assign xb = vb_s1 ? SUM_W'($signed(db)) : '0;

	// s2: pre-add of the symmetric pair
	always_ff @(posedge clk) begin
		sum_s2  <= xa + xb;
		coef_s2 <= vc_s1 ? $signed(dc) : '0;
	end

	// s3: product
	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(coef_s2) * PROD_W'(sum_s2);
	end

	assign acc_rnd = acc_q + RND_BIAS;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
		if (cmd.round) begin
			rnd_q <= acc_rnd[ACC_W-1:FRAC_W];
		end
	end

	always_comb begin
		if (rnd_q > SAT_HI) begin
			sat_val = SAT_HI[SAMPLE_W-1:0];
		end else if (rnd_q < SAT_LO) begin
			sat_val = SAT_LO[SAMPLE_W-1:0];
		end else begin
			sat_val = rnd_q[SAMPLE_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			filtered_q <= sat_val;
		end
	end

	assign stat.out_free   = !out_valid_q || result.ready;
	assign result.valid    = out_valid_q;
	assign result.filtered = filtered_q;
endmodule

// ===== hdl/symmetric_fir_decimator.sv =====
// ----------------------------------------------------------------------------
// symmetric_fir_decimator
// One stage of a linear-phase FIR decimator with a symmetric coefficient set.
// Items on the input channel either load one Q1.17 coefficient of the half
// table (op coefficient; indexes past the table are dropped) or push one
// 24-bit sample into a window of up to 64 taps (op sample). Once the window
// holds tap_count samples a result is produced, and then one on every
// decim_rate-th further sample. The result is sum coef[i]*(x[i]+x[L-1-i])
// plus the center tap for odd L, accumulated exactly, rounded to nearest
// (ties toward plus infinity) and saturated to 24 bits. Coefficient loads
// and non-emitting samples complete when accepted. After a sample that
// produces a result no item is accepted until its tap pairs have passed, one
// per cycle, through a single shared pre-add/multiply/accumulate pipeline,
// the pipeline has drained, the sum is rounded and it is loaded into the
// output register once that is free. The output register holds a finished
// result while the next item is accepted. Configuration registers: index 0
// tap_count (reset 1), index 1 decim_rate (reset 1); out-of-range values are
// clamped, other indexes are ignored. The sample buffer and coefficient
// table need no clearing pass: entries not yet written read as zero.
// ----------------------------------------------------------------------------
module symmetric_fir_decimator (
	input  logic                           clk,
	input  logic                           arst_n,
	sfd_in_if.sink                         feed,
	sfd_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfd_pkg::*;

	sfd_cmd_t  cmd;
	sfd_stat_t stat;

	// sequencer: accepts a transaction only when idle, then walks the
	// tap pairs and hands the result to the output register
	sfd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.feed_valid (feed.valid),
		.feed_op    (feed.op),
		.feed_ready (feed.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// storage and arithmetic
	sfd_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.feed   (feed),
		.result (result)
	);
endmodule
